// ===== rtl/core/mesi_snooping_cache_macros.svh =====
// Assertion macros of the cache RTL.
`ifndef MESI_SNOOPING_CACHE_MACROS_SVH
`define MESI_SNOOPING_CACHE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cache assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cache assertion failed");

`endif

// ===== rtl/core/msc_pkg.sv =====
// ============================================================================
// msc_pkg
// Types, constants and address helpers of the MESI snooping cache.
// ============================================================================
`default_nettype none

package msc_pkg;

  localparam int SET_COUNT   = 64;
  localparam int BLOCK_WORDS = 8;
  localparam int ADDR_BITS   = 20;

  localparam int OFF_BITS   = $clog2(BLOCK_WORDS);
  localparam int SET_BITS   = $clog2(SET_COUNT);
  localparam int TAG_BITS   = ADDR_BITS - OFF_BITS - SET_BITS;
  localparam int DATA_DEPTH = SET_COUNT * BLOCK_WORDS;
  localparam int DATA_AW    = $clog2(DATA_DEPTH);
  localparam int TAG_W      = TAG_BITS + 2;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [31:0]          word_t;
  typedef logic [TAG_BITS-1:0]  tag_t;
  typedef logic [SET_BITS-1:0]  set_idx_t;
  typedef logic [OFF_BITS-1:0]  off_t;
  typedef logic [DATA_AW-1:0]   daddr_t;
  typedef logic [OFF_BITS:0]    fidx_t;

  typedef enum logic [1:0] {CMD_READ, CMD_WRITE, CMD_SNOOP, CMD_FILL} cmd_t;
  typedef enum logic [1:0] {BUS_NONE, BUS_READ, BUS_RDX, BUS_FLUSH} bus_cmd_t;
  typedef enum logic [1:0] {MESI_I, MESI_S, MESI_E, MESI_M} mesi_t;
  typedef enum logic [1:0] {MISS_NONE, MISS_READ, MISS_WRITE} miss_t;
  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EXEC} state_t;

  localparam logic REG_CORE_ID  = 1'b0;
  localparam logic REG_STAT_SEL = 1'b1;

  typedef struct packed {
    logic [1:0] cmd;
    addr_t      core_addr;
    word_t      write_data;
    logic [1:0] bus_command;
    logic [1:0] bus_origin;
    addr_t      bus_address;
    word_t      bus_word;
    logic       bus_shared_in;
  } in_item_t;

  typedef struct packed {
    logic       core_done;
    word_t      read_data;
    logic       drive_flush;
    addr_t      flush_address;
    word_t      flush_data;
    logic       shared_out;
    logic       bus_busy;
    logic [1:0] miss_kind;
    addr_t      miss_address;
    word_t      stat_count;
  } out_item_t;

  typedef struct packed {
    logic [1:0] core_id;
    logic [1:0] stat_select;
  } cfg_t;

  function automatic off_t off_of(addr_t a);
    return a[OFF_BITS-1:0];
  endfunction

  function automatic set_idx_t set_of(addr_t a);
    return a[OFF_BITS+SET_BITS-1:OFF_BITS];
  endfunction

  function automatic tag_t tag_of(addr_t a);
    return a[ADDR_BITS-1:OFF_BITS+SET_BITS];
  endfunction

  function automatic daddr_t daddr_of(addr_t a);
    return a[OFF_BITS+SET_BITS-1:0];
  endfunction

  function automatic addr_t base_of(addr_t a);
    return {a[ADDR_BITS-1:OFF_BITS], {OFF_BITS{1'b0}}};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/msc_in_if.sv =====
// ============================================================================
// msc_in_if
// Valid/ready channel carrying one input item of the cache.
// ============================================================================
`default_nettype none

interface msc_in_if;
  logic              valid;
  logic              ready;
  msc_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/msc_out_if.sv =====
// ============================================================================
// msc_out_if
// Valid/ready channel carrying one result item of the cache.
// ============================================================================
`default_nettype none

interface msc_out_if;
  logic               valid;
  logic               ready;
  msc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/msc_ram.sv =====
// ============================================================================
// msc_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
`default_nettype none

module msc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/msc_cfg_regs.sv =====
// ============================================================================
// msc_cfg_regs
// APB-style register file holding core identity and statistics selection.
// ============================================================================
`default_nettype none

module msc_cfg_regs (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output msc_pkg::cfg_t    cfg
);

  logic [1:0] core_id_r, core_id_nxt;
  logic [1:0] stat_sel_r, stat_sel_nxt;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    core_id_nxt  = core_id_r;
    stat_sel_nxt = stat_sel_r;
    if (wr_en) begin
      case (paddr[2])
        msc_pkg::REG_CORE_ID:  core_id_nxt  = pwdata[1:0];
        msc_pkg::REG_STAT_SEL: stat_sel_nxt = pwdata[1:0];
        default:               core_id_nxt  = core_id_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      core_id_r  <= 2'd0;
      stat_sel_r <= 2'd0;
    end else begin
      core_id_r  <= core_id_nxt;
      stat_sel_r <= stat_sel_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      msc_pkg::REG_CORE_ID:  prdata = {30'd0, core_id_r};
      msc_pkg::REG_STAT_SEL: prdata = {30'd0, stat_sel_r};
      default:               prdata = 32'd0;
    endcase
  end

  assign cfg.core_id     = core_id_r;
  assign cfg.stat_select = stat_sel_r;

endmodule

`default_nettype wire

// ===== rtl/core/msc_engine.sv =====
// ============================================================================
// msc_engine
// Read-modify-write engine over the tag and data memories.
// ============================================================================
`default_nettype none

`include "mesi_snooping_cache_macros.svh"

module msc_engine (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire msc_pkg::cfg_t cfg,
  msc_in_if.sink         in_if,
  msc_out_if.source      out_if
);

  msc_pkg::state_t state_r, state_nxt;
  msc_pkg::daddr_t clr_r;
  msc_pkg::in_item_t item_r;
  msc_pkg::out_item_t out_r, res;
  logic out_valid_r;

  // Control state of the cache.
  msc_pkg::addr_t pa_r, pa_nxt;
  logic pv_r, pv_nxt, ww_r, ww_nxt, cd_r, cd_nxt, ss_r, ss_nxt, fw_r, fw_nxt;
  logic fl_r, fl_nxt;
  msc_pkg::addr_t fb_r, fb_nxt;
  msc_pkg::fidx_t fi_r, fi_nxt;
  msc_pkg::word_t cnt_r [4];
  msc_pkg::word_t cnt_nxt [4];

  // Memory ports.
  logic                        tram_we, dram_we;
  msc_pkg::set_idx_t           tram_waddr, tram_raddr;
  logic [msc_pkg::TAG_W-1:0]   tram_wdata, tram_rdata;
  msc_pkg::daddr_t             dram_waddr, dram_raddr;
  msc_pkg::word_t              dram_wdata, dram_rdata;

  // Engine requests decoded in the execute step.
  logic                        x_twe, x_dwe;
  msc_pkg::set_idx_t           x_twaddr;
  logic [msc_pkg::TAG_W-1:0]   x_twdata;
  msc_pkg::daddr_t             x_dwaddr;
  msc_pkg::word_t              x_dwdata;

  msc_pkg::tag_t  tag_q;
  msc_pkg::mesi_t st_q;
  msc_pkg::addr_t a;
  logic           tmatch, pend;
  msc_pkg::off_t  fidx;

  logic accept;

  assign accept = in_if.valid && in_if.ready;

  msc_ram #(.WIDTH(msc_pkg::TAG_W), .DEPTH(msc_pkg::SET_COUNT)) u_tag_ram (
    .clk(clk), .we(tram_we), .waddr(tram_waddr), .wdata(tram_wdata),
    .raddr(tram_raddr), .rdata(tram_rdata)
  );

  msc_ram #(.WIDTH(32), .DEPTH(msc_pkg::DATA_DEPTH)) u_data_ram (
    .clk(clk), .we(dram_we), .waddr(dram_waddr), .wdata(dram_wdata),
    .raddr(dram_raddr), .rdata(dram_rdata)
  );

  // Read addresses come straight from the item being accepted, or from the flush pointer during a flush.
  always_comb begin
    if (in_if.data.cmd == msc_pkg::CMD_SNOOP) begin
      if (fl_r) begin
        tram_raddr = msc_pkg::set_of(fb_r);
        dram_raddr = {msc_pkg::set_of(fb_r), fi_r[msc_pkg::OFF_BITS-1:0]};
      end else begin
        tram_raddr = msc_pkg::set_of(in_if.data.bus_address);
        dram_raddr = msc_pkg::daddr_of(in_if.data.bus_address);
      end
    end else begin
      tram_raddr = msc_pkg::set_of(in_if.data.core_addr);
      dram_raddr = msc_pkg::daddr_of(in_if.data.core_addr);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      msc_pkg::ST_CLEAR: begin
        if (clr_r == msc_pkg::daddr_t'(msc_pkg::DATA_DEPTH - 1)) state_nxt = msc_pkg::ST_IDLE;
      end
      msc_pkg::ST_IDLE: begin
        if (accept) state_nxt = msc_pkg::ST_EXEC;
      end
      msc_pkg::ST_EXEC: state_nxt = msc_pkg::ST_IDLE;
      default: state_nxt = msc_pkg::ST_CLEAR;
    endcase
  end

  // State outputs: handshake and memory write selection.
  always_comb begin
    in_if.ready = (state_r == msc_pkg::ST_IDLE) && (!out_valid_r || out_if.ready);
    tram_we    = 1'b0;
    tram_waddr = x_twaddr;
    tram_wdata = x_twdata;
    dram_we    = 1'b0;
    dram_waddr = x_dwaddr;
    dram_wdata = x_dwdata;
    case (state_r)
      msc_pkg::ST_CLEAR: begin
        tram_we    = 1'b1;
        tram_waddr = clr_r[msc_pkg::SET_BITS-1:0];
        tram_wdata = '0;
        dram_we    = 1'b1;
        dram_waddr = clr_r;
        dram_wdata = '0;
      end
      msc_pkg::ST_EXEC: begin
        tram_we = x_twe;
        dram_we = x_dwe;
      end
      default: begin
        tram_we = 1'b0;
      end
    endcase
  end

  assign tag_q = tram_rdata[msc_pkg::TAG_W-1:2];
  assign st_q  = msc_pkg::mesi_t'(tram_rdata[1:0]);
  assign fidx  = fi_r[msc_pkg::OFF_BITS-1:0];

  // Execute step: tag check, MESI transitions and bookkeeping.
  always_comb begin
    pa_nxt = pa_r; pv_nxt = pv_r; ww_nxt = ww_r; cd_nxt = cd_r;
    ss_nxt = ss_r; fw_nxt = fw_r; fl_nxt = fl_r; fb_nxt = fb_r; fi_nxt = fi_r;
    for (int k = 0; k < 4; k++) cnt_nxt[k] = cnt_r[k];
    res = '0;
    a = (item_r.cmd == msc_pkg::CMD_SNOOP) ? item_r.bus_address : item_r.core_addr;
    tmatch = (tag_q == msc_pkg::tag_of(a));
    pend = pv_r && (pa_r == a);
    x_twe = 1'b0;
    x_twaddr = msc_pkg::set_of(a);
    x_twdata = {tag_q, st_q};
    x_dwe = 1'b0;
    x_dwaddr = msc_pkg::daddr_of(a);
    x_dwdata = item_r.write_data;
    case (item_r.cmd)
      msc_pkg::CMD_READ: begin
        if (st_q != msc_pkg::MESI_I && tmatch) begin
          if (pend) pv_nxt = 1'b0;
          else cnt_nxt[0] = cnt_r[0] + 32'd1;
          res.core_done = 1'b1;
          res.read_data = dram_rdata;
          cd_nxt = 1'b0;
        end else if (!pend) begin
          if (!cd_r) begin
            cd_nxt = 1'b1;
          end else begin
            cnt_nxt[2] = cnt_r[2] + 32'd1;
            ww_nxt = 1'b0;
            pa_nxt = a;
            pv_nxt = 1'b1;
            ss_nxt = 1'b0;
            cd_nxt = 1'b0;
          end
        end
      end
      msc_pkg::CMD_WRITE: begin
        if ((st_q == msc_pkg::MESI_M || st_q == msc_pkg::MESI_E) && tmatch) begin
          if (pend) pv_nxt = 1'b0;
          else cnt_nxt[1] = cnt_r[1] + 32'd1;
          x_dwe = 1'b1;
          x_twe = 1'b1;
          x_twdata = {tag_q, msc_pkg::MESI_M};
          cd_nxt = 1'b0;
          res.core_done = 1'b1;
        end else if (!ww_r && !cd_r) begin
          cd_nxt = 1'b1;
        end else begin
          if (!ww_r && !pend) begin
            cnt_nxt[3] = cnt_r[3] + 32'd1;
            cd_nxt = 1'b0;
          end
          ww_nxt = 1'b1;
          pa_nxt = a;
          pv_nxt = 1'b1;
        end
      end
      msc_pkg::CMD_SNOOP: begin
        if (fl_r) begin
          res.drive_flush   = 1'b1;
          res.flush_address = {fb_r[msc_pkg::ADDR_BITS-1:msc_pkg::OFF_BITS], fidx};
          res.flush_data    = dram_rdata;
          res.shared_out    = 1'b1;
          fi_nxt = {1'b0, fidx} + msc_pkg::fidx_t'(1);
          if (fi_nxt >= msc_pkg::fidx_t'(msc_pkg::BLOCK_WORDS)) fl_nxt = 1'b0;
        end else if ((item_r.bus_command == msc_pkg::BUS_READ ||
                      item_r.bus_command == msc_pkg::BUS_RDX) &&
                     item_r.bus_origin != cfg.core_id) begin
          if (st_q != msc_pkg::MESI_I && tmatch) begin
            if (item_r.bus_command == msc_pkg::BUS_READ && st_q != msc_pkg::MESI_M)
              res.shared_out = 1'b1;
            if (st_q == msc_pkg::MESI_M || st_q == msc_pkg::MESI_E) begin
              x_twe = 1'b1;
              x_twdata = {tag_q, (item_r.bus_command == msc_pkg::BUS_READ) ?
                                 msc_pkg::MESI_S : msc_pkg::MESI_I};
              if (st_q == msc_pkg::MESI_M) begin
                fl_nxt = 1'b1;
                fb_nxt = msc_pkg::base_of(a);
                fi_nxt = '0;
              end
            end else if (item_r.bus_command == msc_pkg::BUS_RDX) begin
              x_twe = 1'b1;
              x_twdata = {tag_q, msc_pkg::MESI_I};
            end
          end
        end else if (item_r.bus_command == msc_pkg::BUS_FLUSH) begin
          if (item_r.bus_shared_in) ss_nxt = 1'b1;
          if (fw_r && pv_r && msc_pkg::base_of(a) == msc_pkg::base_of(pa_r)) begin
            x_dwe = 1'b1;
            x_dwdata = item_r.bus_word;
            if (msc_pkg::off_of(a) == msc_pkg::off_t'(msc_pkg::BLOCK_WORDS - 1)) begin
              x_twe = 1'b1;
              fw_nxt = 1'b0;
              if (ww_r) begin
                x_twdata = {msc_pkg::tag_of(a), msc_pkg::MESI_M};
                ww_nxt = 1'b0;
              end else begin
                x_twdata = {msc_pkg::tag_of(a), ss_nxt ? msc_pkg::MESI_S : msc_pkg::MESI_E};
              end
            end
          end
        end
      end
      msc_pkg::CMD_FILL: fw_nxt = 1'b1;
      default: fw_nxt = fw_r;
    endcase
    res.bus_busy     = fl_nxt;
    res.miss_kind    = pv_nxt ? (ww_nxt ? msc_pkg::MISS_WRITE : msc_pkg::MISS_READ)
                              : msc_pkg::MISS_NONE;
    res.miss_address = pv_nxt ? pa_nxt : '0;
    res.stat_count   = cnt_nxt[cfg.stat_select];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= msc_pkg::ST_CLEAR;
      clr_r <= '0;
      out_valid_r <= 1'b0;
      pa_r <= '0; pv_r <= 1'b0; ww_r <= 1'b0; cd_r <= 1'b0; ss_r <= 1'b0;
      fw_r <= 1'b0; fl_r <= 1'b0; fb_r <= '0; fi_r <= '0;
      for (int k = 0; k < 4; k++) cnt_r[k] <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == msc_pkg::ST_CLEAR) clr_r <= clr_r + msc_pkg::daddr_t'(1);
      if (state_r == msc_pkg::ST_EXEC) begin
        out_valid_r <= 1'b1;
        pa_r <= pa_nxt; pv_r <= pv_nxt; ww_r <= ww_nxt; cd_r <= cd_nxt;
        ss_r <= ss_nxt; fw_r <= fw_nxt; fl_r <= fl_nxt; fb_r <= fb_nxt; fi_r <= fi_nxt;
        for (int k = 0; k < 4; k++) cnt_r[k] <= cnt_nxt[k];
      end else if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item_r <= in_if.data;
    if (state_r == msc_pkg::ST_EXEC) out_r <= res;
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_r;

  `MSC_ASSERT_NXT(a_accept_exec, clk, rst_n, accept, state_r == msc_pkg::ST_EXEC)
  `MSC_ASSERT_IMP(a_no_accept_clear, clk, rst_n, state_r == msc_pkg::ST_CLEAR, !in_if.ready)
  `MSC_ASSERT_IMP(a_flush_idx, clk, rst_n, fl_r, fi_r < msc_pkg::fidx_t'(msc_pkg::BLOCK_WORDS))
  `MSC_ASSERT_NXT(a_flush_out, clk, rst_n,
                  state_r == msc_pkg::ST_EXEC && fl_r && item_r.cmd == msc_pkg::CMD_SNOOP,
                  out_valid_r && out_r.drive_flush && out_r.shared_out)

endmodule

`default_nettype wire

// ===== rtl/core/mesi_snooping_cache.sv =====
// ============================================================================
// mesi_snooping_cache
// Direct-mapped write-back cache of 64 sets by 8 words, coherent by MESI snooping.
// ============================================================================
// Every item (core read, core write, one snooped bus cycle, or the notice that
// a fill request went out) yields exactly one result item. In the cycle an
// item is accepted the tag and data memories are read at the item's set, and
// in the next cycle the engine checks the tag, applies the MESI transition,
// writes the memories back and loads the result register; the next item may
// be accepted in the cycle after that, provided the result before it is taken
// in that same cycle or already has been. The single read-modify-write pass
// over the registered-read tag and data memories means no item is accepted
// before the one before it is through, and a result that is held back stalls
// the input for as long as it waits.
// After reset a clearing pass zeroes the data memory and sets every tag entry
// to tag zero, Invalid; no item is accepted until it ends, while configuration
// writes are taken at any time.
`default_nettype none

module mesi_snooping_cache (
  input  wire logic        clk,
  input  wire logic        rst_n,
  msc_in_if.sink           in_if,
  msc_out_if.source        out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  // Register 0 at byte 0 holds the core identity, register 1 at byte 4 the
  // statistics counter selection.
  msc_pkg::cfg_t cfg;

  msc_cfg_regs u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  // The engine holds the coherence state and both memories.
  msc_engine u_engine (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .in_if(in_if), .out_if(out_if)
  );

endmodule

`default_nettype wire
